@@ design/pcbs_pkg.sv @@
`timescale 1ns / 1ps
package pcbs_pkg;
  localparam int MaxBoxes   = 64;
  localparam int NumClasses = 80;
  localparam int IdxW       = $clog2(MaxBoxes);
  localparam int CntW       = $clog2(MaxBoxes + 1);
  localparam logic [15:0] OnePixel = 16'd16;
  localparam logic [15:0] ThrReset = 16'd32768;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
    logic [15:0] score;
    logic [6:0]  label;
  } box_t;

  typedef struct packed {
    logic            kept;
    logic [IdxW-1:0] slot;
  } ord_t;

  typedef enum logic [16:0] {
    S_LOAD = 17'h00001,
    S_SRDI = 17'h00002,
    S_SKEY = 17'h00004,
    S_SCHK = 17'h00008,
    S_SORD = 17'h00010,
    S_SCMP = 17'h00020,
    S_SUPA = 17'h00040,
    S_SUPR = 17'h00080,
    S_SUPL = 17'h00100,
    S_TEST = 17'h00200,
    S_TRD  = 17'h00400,
    S_TBOX = 17'h00800,
    S_AREA = 17'h01000,
    S_HIT  = 17'h02000,
    S_EMRD = 17'h04000,
    S_EMOR = 17'h08000,
    S_EMIT = 17'h10000
  } state_e;
endpackage

@@ design/pcbs_overlap.sv @@
`timescale 1ns / 1ps
module pcbs_overlap
  import pcbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        step_i,
  input  logic [1:0]  phase_i,
  input  box_t        a_i,
  input  box_t        b_i,
  input  logic [15:0] thr_i,
  output logic        hit_o
);
  logic signed [17:0] aw_q, ah_q, bw_q, bh_q, iw_q, ih_q;
  logic signed [35:0] area_a_q, area_b_q, inter_q;
  logic signed [37:0] uni_q;
  logic signed [53:0] rhs_q;
  logic signed [16:0] xx1, yy1, xx2, yy2;
  logic signed [17:0] iw_d, ih_d;

  function automatic logic signed [17:0] ext(input logic [15:0] hi, input logic [15:0] lo);
    ext = $signed({2'b00, hi}) - $signed({2'b00, lo}) + $signed({2'b00, OnePixel});
  endfunction

  always_comb begin
    xx1 = (a_i.x_min > b_i.x_min) ? {1'b0, a_i.x_min} : {1'b0, b_i.x_min};
    yy1 = (a_i.y_min > b_i.y_min) ? {1'b0, a_i.y_min} : {1'b0, b_i.y_min};
    xx2 = (a_i.x_max < b_i.x_max) ? {1'b0, a_i.x_max} : {1'b0, b_i.x_max};
    yy2 = (a_i.y_max < b_i.y_max) ? {1'b0, a_i.y_max} : {1'b0, b_i.y_max};
    iw_d = 18'(xx2) - 18'(xx1) + $signed({2'b00, OnePixel});
    ih_d = 18'(yy2) - 18'(yy1) + $signed({2'b00, OnePixel});
    if (iw_d < 0) iw_d = '0;
    if (ih_d < 0) ih_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      unique case (phase_i)
        2'd0: begin
          aw_q <= ext(a_i.x_max, a_i.x_min);
          ah_q <= ext(a_i.y_max, a_i.y_min);
          bw_q <= ext(b_i.x_max, b_i.x_min);
          bh_q <= ext(b_i.y_max, b_i.y_min);
          iw_q <= iw_d;
          ih_q <= ih_d;
        end
        2'd1: begin
          area_a_q <= aw_q * ah_q;
          area_b_q <= bw_q * bh_q;
          inter_q  <= iw_q * ih_q;
        end
        2'd2: begin
          uni_q <= 38'(area_a_q) + 38'(area_b_q) - 38'(inter_q);
        end
        default: begin
          rhs_q <= $signed({1'b0, thr_i}) * uni_q;
        end
      endcase
    end
  end

  logic signed [54:0] lhs;
  assign lhs = {3'b000, inter_q, 16'h0000};
  always_comb begin
    if (uni_q > 0)      hit_o = lhs >= 55'(rhs_q);
    else if (uni_q < 0) hit_o = lhs <= 55'(rhs_q);
    else                hit_o = inter_q > 0;
  end
endmodule

@@ design/per_class_box_suppression.sv @@
`timescale 1ns / 1ps
// Per-class greedy box suppression. Box words load one per cycle into a
// 64-entry box memory until a word with last_box_i; a word whose label is
// 80 or more is dropped, and a box beyond 64 is dropped and sets overflow_o
// for the set. The set is then insertion-sorted (class ascending, score
// descending, arrival order on ties) into a rank memory that also holds the
// kept flags: each box is read and its key latched, then it is compared
// with the rank above and moves up while it goes ahead, until rank 0.
// Suppression walks the ranks, skipping those found suppressed; each kept
// rank reads the later ranks of its class in turn, and each pair of kept
// boxes is sent through the 4-stage overlap unit (three 18x18 products,
// then one 17x38 product). Survivors then leave in rank order, held while
// out_stall_i is high. in_stall_o stays high from the last word until the
// set is out. Write iou_threshold through cfg_we_i only while idle.
module per_class_box_suppression
  import pcbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] x_min_i,
  input  logic [15:0] y_min_i,
  input  logic [15:0] x_max_i,
  input  logic [15:0] y_max_i,
  input  logic [15:0] score_i,
  input  logic [6:0]  label_i,
  input  logic        last_box_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_x_min_o,
  output logic [15:0] out_y_min_o,
  output logic [15:0] out_x_max_o,
  output logic [15:0] out_y_max_o,
  output logic [15:0] out_score_o,
  output logic [6:0]  out_label_o,
  output logic        last_kept_o,
  output logic        overflow_o
);
  box_t box_mem [MaxBoxes];
  ord_t ord_mem [MaxBoxes];

  state_e          st_q;
  logic [15:0]     thr_q;
  logic [CntW-1:0] cnt_q, i_q, j_q, k_q;
  logic            ovf_q;
  logic [1:0]      ph_q;
  logic [IdxW-1:0] lastk_q;
  box_t            ai_q, ra_q, rb_q;
  logic [IdxW-1:0] oa_q;
  ord_t            ob_q;
  logic            out_v_q;
  box_t            out_q;
  logic            out_last_q, out_ovf_q;
  logic            hit;

  logic            in_acc, in_ok, bwe, out_load, goes_ahead;
  box_t            in_box, brd_q;
  logic [IdxW-1:0] baddr, ora, owa;
  ord_t            owd, ord_q;
  logic            owe;

  assign in_stall_o = (st_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_ok      = (label_i < 7'(NumClasses));
  assign in_box     = '{x_min: x_min_i, y_min: y_min_i, x_max: x_max_i,
                        y_max: y_max_i, score: score_i, label: label_i};
  assign bwe        = in_acc && in_ok && (cnt_q < CntW'(MaxBoxes));
  assign out_load   = (st_q == S_EMIT) && (!out_v_q || !out_stall_i);
  assign goes_ahead = (ai_q.label != brd_q.label) ? (ai_q.label < brd_q.label)
                                                  : (ai_q.score > brd_q.score);

  // box memory: one write port, one registered read port
  always_comb begin
    unique case (st_q)
      S_SRDI:                        baddr = i_q[IdxW-1:0];
      S_SORD, S_SUPR, S_TRD, S_EMOR: baddr = ord_q.slot;
      S_EMIT:                        baddr = oa_q;
      default:                       baddr = cnt_q[IdxW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bwe) box_mem[cnt_q[IdxW-1:0]] <= in_box;
    brd_q <= box_mem[baddr];
  end

  // rank memory: slot and kept flag per sorted position
  always_comb begin
    unique case (st_q)
      S_SCHK:         ora = IdxW'(k_q - 1'b1);
      S_SUPA, S_EMRD: ora = i_q[IdxW-1:0];
      S_TEST:         ora = j_q[IdxW-1:0];
      default:        ora = '0;
    endcase
  end

  always_comb begin
    owe = 1'b0;
    owa = k_q[IdxW-1:0];
    owd = '{kept: 1'b1, slot: i_q[IdxW-1:0]};
    unique case (st_q)
      S_SCHK: owe = (k_q == '0);
      S_SCMP: begin
        owe = 1'b1;
        if (goes_ahead) owd.slot = oa_q;
      end
      S_HIT: begin
        owe = hit;
        owa = j_q[IdxW-1:0];
        owd = '{kept: 1'b0, slot: ob_q.slot};
      end
      default: owe = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (owe) ord_mem[owa] <= owd;
    ord_q <= ord_mem[ora];
  end

  pcbs_overlap u_ovl (
    .clk_i  (clk_i),
    .step_i (st_q == S_AREA),
    .phase_i(ph_q),
    .a_i    (ra_q),
    .b_i    (rb_q),
    .thr_i  (thr_q),
    .hit_o  (hit)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == S_SKEY) ai_q <= brd_q;
    if (st_q == S_SORD || st_q == S_EMOR) oa_q <= ord_q.slot;
    if (st_q == S_SUPL) ra_q <= brd_q;
    if (st_q == S_TRD) ob_q <= ord_q;
    if (st_q == S_TBOX) rb_q <= brd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; thr_q <= ThrReset; cnt_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= '0; lastk_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      unique case (st_q)
        S_LOAD: begin
          if (in_acc) begin
            if (bwe) cnt_q <= cnt_q + 1'b1;
            if (in_ok && !bwe) ovf_q <= 1'b1;
            if (last_box_i) begin
              i_q <= '0;
              if (cnt_q != '0 || bwe) st_q <= S_SRDI;
            end
          end
        end
        S_SRDI: begin
          if (i_q == cnt_q) begin
            i_q <= '0; st_q <= S_SUPA;
          end else begin
            k_q <= i_q; st_q <= S_SKEY;
          end
        end
        S_SKEY: st_q <= S_SCHK;
        S_SCHK: begin
          if (k_q == '0) begin
            i_q <= i_q + 1'b1; st_q <= S_SRDI;
          end else begin
            st_q <= S_SORD;
          end
        end
        S_SORD: st_q <= S_SCMP;
        S_SCMP: begin
          if (goes_ahead) begin
            k_q <= k_q - 1'b1; st_q <= S_SCHK;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_SRDI;
          end
        end
        S_SUPA: begin
          if (i_q == cnt_q) begin
            i_q <= '0; st_q <= S_EMRD;
          end else begin
            st_q <= S_SUPR;
          end
        end
        S_SUPR: begin
          if (ord_q.kept) begin
            lastk_q <= i_q[IdxW-1:0]; j_q <= i_q + 1'b1; st_q <= S_SUPL;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_SUPA;
          end
        end
        S_SUPL: st_q <= S_TEST;
        S_TEST: begin
          if (j_q == cnt_q) begin
            i_q <= i_q + 1'b1; st_q <= S_SUPA;
          end else begin
            st_q <= S_TRD;
          end
        end
        S_TRD: st_q <= S_TBOX;
        S_TBOX: begin
          if (brd_q.label != ra_q.label) begin
            i_q <= i_q + 1'b1; st_q <= S_SUPA;
          end else if (!ob_q.kept) begin
            j_q <= j_q + 1'b1; st_q <= S_TEST;
          end else begin
            ph_q <= '0; st_q <= S_AREA;
          end
        end
        S_AREA: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 2'd3) st_q <= S_HIT;
        end
        S_HIT: begin
          j_q <= j_q + 1'b1; st_q <= S_TEST;
        end
        S_EMRD: begin
          if (i_q == cnt_q) begin
            cnt_q <= '0; ovf_q <= 1'b0; st_q <= S_LOAD;
          end else begin
            st_q <= S_EMOR;
          end
        end
        S_EMOR: begin
          if (ord_q.kept) begin
            st_q <= S_EMIT;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_EMRD;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            i_q <= i_q + 1'b1; st_q <= S_EMRD;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0; out_q <= '0; out_last_q <= 1'b0; out_ovf_q <= 1'b0;
    end else if (out_load) begin
      out_v_q    <= 1'b1;
      out_q      <= brd_q;
      out_last_q <= (i_q[IdxW-1:0] == lastk_q);
      out_ovf_q  <= ovf_q;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_min_o = out_q.x_min;
  assign out_y_min_o = out_q.y_min;
  assign out_x_max_o = out_q.x_max;
  assign out_y_max_o = out_q.y_max;
  assign out_score_o = out_q.score;
  assign out_label_o = out_q.label;
  assign last_kept_o = out_last_q;
  assign overflow_o  = out_ovf_q;
endmodule
